[rtl/coalescing_report_ring_defines.svh]
// Assertion helpers for the ring engine; each expects clk and rst_n in scope.
`ifndef COALESCING_REPORT_RING_DEFINES_SVH
`define COALESCING_REPORT_RING_DEFINES_SVH

// Same-cycle implication.
`define CRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crr: check failed");

// Next-cycle implication.
`define CRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crr: check failed");

`endif

[rtl/crr_pkg.sv]
package crr_pkg;

  localparam int DEPTH       = 16;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int OCC_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = SLOT_W + 1;
  localparam int POS_W       = 4;
  localparam int KEY_W       = 56;
  localparam int PAY_W       = 48;
  localparam int CNT_W       = 16;
  localparam int TOT_W       = 32;
  localparam int OCC_OUT_W   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef struct packed {
    logic [1:0]       op;
    key_t             key;
    pay_t             pay;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [15:0]          origin_id;
    logic [7:0]           verdict;
    logic [15:0]          subject_id;
    logic [15:0]          subject_index;
    logic [31:0]          arrival_time;
    logic [15:0]          detail_id;
    logic [CNT_W-1:0]     occurrence_count;
    logic                 coalesced;
    logic                 evicted_oldest;
    logic [OCC_OUT_W-1:0] occupied_count;
    logic [TOT_W-1:0]     appended_count;
    logic [TOT_W-1:0]     discarded_count;
  } res_t;

endpackage

[rtl/crr_queue.sv]
module crr_queue import crr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_data
);

  cmd_t               slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/crr_engine.sv]
`include "coalescing_report_ring_defines.svh"

module crr_engine import crr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int PC_W = (OCC_W > POS_W) ? OCC_W : POS_W;
  localparam int OCCX_W = OCC_W + OCC_OUT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_MERGE = 3'd2;
  localparam logic [2:0] ST_NEW   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] v);
    return (v == '1) ? v : v + TOT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [OCC_OUT_W-1:0] occ_out(input logic [OCC_W-1:0] v);
    logic [OCCX_W-1:0] x;
    x = OCCX_W'(v);
    return x[OCC_OUT_W-1:0];
  endfunction

  // Entry store
  key_t             key_mem [DEPTH];
  pay_t             pay_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];

  key_t             rd_key_r;
  pay_t             rd_pay_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_addr;
  key_t             wr_key;
  pay_t             wr_pay;
  logic [CNT_W-1:0] wr_cnt;

  logic [2:0]        state_r, state_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [TOT_W-1:0]  app_r, app_nxt;
  logic [TOT_W-1:0]  disc_r, disc_nxt;
  logic [OCC_W-1:0]  idx_r, idx_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0] chk_slot_r, chk_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;
  res_t              res;
  logic              res_load;
  logic              out_free;
  logic              hit;
  logic              pos_ok;
  logic [SLOT_W-1:0] scan_slot;
  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] read_slot;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = !out_valid_r || out_ready;
  assign hit       = chk_v_r && (rd_key_r == cur_r.key);
  assign pos_ok    = PC_W'(cmd.pos) < PC_W'(occ_r);
  assign scan_slot = slot_wrap(SUM_W'(oldest_r) + SUM_W'(idx_r) - SUM_W'(1));
  assign new_slot  = slot_wrap(SUM_W'(oldest_r) + SUM_W'(occ_r));
  assign read_slot = slot_wrap(SUM_W'(oldest_r) + SUM_W'(cmd.pos));

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    oldest_nxt   = oldest_r;
    occ_nxt      = occ_r;
    app_nxt      = app_r;
    disc_nxt     = disc_r;
    idx_nxt      = idx_r;
    chk_v_nxt    = chk_v_r;
    chk_slot_nxt = chk_slot_r;
    cmd_pop      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = read_slot;
    wr_en        = 1'b0;
    wr_addr      = new_slot;
    wr_key       = cur_r.key;
    wr_pay       = cur_r.pay;
    wr_cnt       = CNT_W'(1);
    res_load     = 1'b0;
    res          = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_APPEND: begin
              cmd_pop   = 1'b1;
              cur_nxt   = cmd;
              app_nxt   = sat_tot(app_r);
              idx_nxt   = occ_r;
              chk_v_nxt = 1'b0;
              state_nxt = (occ_r == '0) ? ST_NEW : ST_SCAN;
            end
            OP_READ: begin
              if (pos_ok) begin
                cmd_pop   = 1'b1;
                cur_nxt   = cmd;
                rd_en     = 1'b1;
                state_nxt = ST_READ;
              end else if (out_free) begin
                cmd_pop  = 1'b1;
                res_load = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                cmd_pop    = 1'b1;
                res_load   = 1'b1;
                oldest_nxt = '0;
                occ_nxt    = '0;
                app_nxt    = '0;
                disc_nxt   = '0;
              end
            end
            default: begin
              if (out_free) begin
                cmd_pop  = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        // newest to oldest, one read issued per cycle, each compared in the cycle after
        if (hit) begin
          state_nxt = ST_MERGE;
        end else if (idx_r != '0) begin
          rd_en        = 1'b1;
          rd_addr      = scan_slot;
          chk_slot_nxt = scan_slot;
          idx_nxt      = idx_r - OCC_W'(1);
          chk_v_nxt    = 1'b1;
        end else begin
          state_nxt = ST_NEW;
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = chk_slot_r;
          wr_key    = rd_key_r;
          wr_pay    = cur_r.pay;
          wr_cnt    = sat_cnt(rd_cnt_r);
          res_load  = 1'b1;
          res.origin_id        = rd_key_r[55:40];
          res.verdict          = rd_key_r[39:32];
          res.subject_id       = rd_key_r[31:16];
          res.subject_index    = rd_key_r[15:0];
          res.arrival_time     = cur_r.pay[47:16];
          res.detail_id        = cur_r.pay[15:0];
          res.occurrence_count = sat_cnt(rd_cnt_r);
          res.coalesced        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_NEW: begin
        if (out_free) begin
          wr_en    = 1'b1;
          res_load = 1'b1;
          if (occ_r == OCC_W'(DEPTH)) begin
            // full: overwrite the oldest slot and advance past it
            oldest_nxt         = slot_wrap(SUM_W'(oldest_r) + SUM_W'(1));
            disc_nxt           = sat_tot(disc_r);
            res.evicted_oldest = 1'b1;
          end else begin
            occ_nxt = occ_r + OCC_W'(1);
          end
          res.origin_id        = cur_r.key[55:40];
          res.verdict          = cur_r.key[39:32];
          res.subject_id       = cur_r.key[31:16];
          res.subject_index    = cur_r.key[15:0];
          res.arrival_time     = cur_r.pay[47:16];
          res.detail_id        = cur_r.pay[15:0];
          res.occurrence_count = CNT_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          res_load = 1'b1;
          res.origin_id        = rd_key_r[55:40];
          res.verdict          = rd_key_r[39:32];
          res.subject_id       = rd_key_r[31:16];
          res.subject_index    = rd_key_r[15:0];
          res.arrival_time     = rd_pay_r[47:16];
          res.detail_id        = rd_pay_r[15:0];
          res.occurrence_count = rd_cnt_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.occupied_count  = occ_out(occ_nxt);
    res.appended_count  = app_nxt;
    res.discarded_count = disc_nxt;

    out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      occ_r       <= '0;
      app_r       <= '0;
      disc_r      <= '0;
      idx_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      occ_r       <= occ_nxt;
      app_r       <= app_nxt;
      disc_r      <= disc_nxt;
      idx_r       <= idx_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    chk_slot_r <= chk_slot_nxt;
    if (res_load) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
      rd_cnt_r <= cnt_mem[rd_addr];
    end
  end

  `CRR_ASSERT_IMPL(a_occ_bound, 1'b1, occ_r <= OCC_W'(DEPTH))
  `CRR_ASSERT_IMPL(a_oldest_moves_when_full, oldest_r != '0, occ_r == OCC_W'(DEPTH))
  `CRR_ASSERT_NEXT(a_merge_keeps_occ, state_r == ST_MERGE, occ_r == $past(occ_r))

endmodule

[rtl/coalescing_report_ring.sv]
// Coalescing report ring: a 16-entry circular log that merges repeated reports.
// Input channel (in_valid/in_ready): one operation per transfer - append,
// read by age position, or clear. Result channel (out_valid/out_ready): exactly
// one result per operation, in order.
// Operations enter a two-entry command queue, so up to two can be taken while
// the engine works or a result waits in the output register.
// An append scans the held entries, or skips the scan on an empty log, and then
// merges into the matching entry or writes a new one. The engine scans the entry
// memory one slot per cycle through its single registered read port, newest
// first, and stops at the first match. A read of a held position goes through
// that port; clears and empty-position reads are answered without it. One
// operation is in the engine at a time.
// Reset (rst_n low, synchronous) empties the log, zeroes both totals and drops
// queued operations and any pending result; entry contents are not cleared.
// A stalled receiver holds the result in the output register; the engine then
// waits before writing its next result, and the queue fills and drops in_ready.
module coalescing_report_ring import crr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_origin_id,
  input  logic [7:0]  in_verdict,
  input  logic [15:0] in_subject_id,
  input  logic [15:0] in_subject_index,
  input  logic [31:0] in_arrival_time,
  input  logic [15:0] in_detail_id,
  input  logic [3:0]  in_read_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_entry_origin_id,
  output logic [7:0]  out_entry_verdict,
  output logic [15:0] out_entry_subject_id,
  output logic [15:0] out_entry_subject_index,
  output logic [31:0] out_entry_arrival_time,
  output logic [15:0] out_entry_detail_id,
  output logic [15:0] out_entry_occurrence_count,
  output logic        out_coalesced,
  output logic        out_evicted_oldest,
  output logic [4:0]  out_occupied_count,
  output logic [31:0] out_appended_count,
  output logic [31:0] out_discarded_count
);

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  res_t res;

  // pack the report into key and payload words for the engine
  always_comb begin
    in_cmd.op  = in_operation;
    in_cmd.key = {in_origin_id, in_verdict, in_subject_id, in_subject_index};
    in_cmd.pay = {in_arrival_time, in_detail_id};
    in_cmd.pos = in_read_position;
  end

  crr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (in_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_cmd)
  );

  crr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_entry_origin_id        = res.origin_id;
  assign out_entry_verdict          = res.verdict;
  assign out_entry_subject_id       = res.subject_id;
  assign out_entry_subject_index    = res.subject_index;
  assign out_entry_arrival_time     = res.arrival_time;
  assign out_entry_detail_id        = res.detail_id;
  assign out_entry_occurrence_count = res.occurrence_count;
  assign out_coalesced              = res.coalesced;
  assign out_evicted_oldest         = res.evicted_oldest;
  assign out_occupied_count         = res.occupied_count;
  assign out_appended_count         = res.appended_count;
  assign out_discarded_count        = res.discarded_count;

endmodule

[tb/sv/tb_coalescing_report_ring.sv]
`timescale 1ns / 100ps

module tb_coalescing_report_ring;
  import crr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE = 24;
  localparam int MERGE_REPEATS = 12;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] origin_id;
    logic [7:0]  verdict;
    logic [15:0] subject_id;
    logic [15:0] subject_index;
    logic [31:0] arrival_time;
    logic [15:0] detail_id;
    logic [3:0]  read_position;
  } report_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_APPEND;
  logic [15:0] in_origin_id = '0;
  logic [7:0]  in_verdict = '0;
  logic [15:0] in_subject_id = '0;
  logic [15:0] in_subject_index = '0;
  logic [31:0] in_arrival_time = '0;
  logic [15:0] in_detail_id = '0;
  logic [3:0]  in_read_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_entry_origin_id;
  logic [7:0]  out_entry_verdict;
  logic [15:0] out_entry_subject_id;
  logic [15:0] out_entry_subject_index;
  logic [31:0] out_entry_arrival_time;
  logic [15:0] out_entry_detail_id;
  logic [15:0] out_entry_occurrence_count;
  logic        out_coalesced;
  logic        out_evicted_oldest;
  logic [4:0]  out_occupied_count;
  logic [31:0] out_appended_count;
  logic [31:0] out_discarded_count;

  coalescing_report_ring DUT (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_operation               (in_operation),
    .in_origin_id               (in_origin_id),
    .in_verdict                 (in_verdict),
    .in_subject_id              (in_subject_id),
    .in_subject_index           (in_subject_index),
    .in_arrival_time            (in_arrival_time),
    .in_detail_id               (in_detail_id),
    .in_read_position           (in_read_position),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_entry_origin_id        (out_entry_origin_id),
    .out_entry_verdict          (out_entry_verdict),
    .out_entry_subject_id       (out_entry_subject_id),
    .out_entry_subject_index    (out_entry_subject_index),
    .out_entry_arrival_time     (out_entry_arrival_time),
    .out_entry_detail_id        (out_entry_detail_id),
    .out_entry_occurrence_count (out_entry_occurrence_count),
    .out_coalesced              (out_coalesced),
    .out_evicted_oldest         (out_evicted_oldest),
    .out_occupied_count         (out_occupied_count),
    .out_appended_count         (out_appended_count),
    .out_discarded_count        (out_discarded_count)
  );

  always #2 clk = ~clk;

  // Shadow copy of the ring
  key_t              log_key [DEPTH];
  pay_t              log_pay [DEPTH];
  logic [CNT_W-1:0]  log_occ [DEPTH];
  logic [SLOT_W-1:0] log_oldest;
  logic [4:0]        log_held;
  logic [TOT_W-1:0]  log_appends;
  logic [TOT_W-1:0]  log_discards;

  res_t ring_outcomes [$];
  res_t got;
  res_t want;
  int   mismatches = 0;
  int   cycles = 0;

  key_t key_pool [POOL_SIZE];
  int   pool_used = 1;

  bit tx_bursty = 1'b0;
  int burst_left = 0;
  bit rx_stall = 1'b0;
  bit rx_state = 1'b1;
  int rx_run = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  bit rx_ready_next;

  function automatic res_t with_entry(res_t res, logic [SLOT_W-1:0] slot);
    res.origin_id        = log_key[slot][55:40];
    res.verdict          = log_key[slot][39:32];
    res.subject_id       = log_key[slot][31:16];
    res.subject_index    = log_key[slot][15:0];
    res.arrival_time     = log_pay[slot][47:16];
    res.detail_id        = log_pay[slot][15:0];
    res.occurrence_count = log_occ[slot];
    return res;
  endfunction

  function automatic res_t apply_to_ring(report_req_t r);
    res_t              res;
    key_t              k;
    pay_t              p;
    logic [SLOT_W-1:0] slot;
    bit                hit;
    res  = '0;
    hit  = 1'b0;
    slot = '0;
    k = {r.origin_id, r.verdict, r.subject_id, r.subject_index};
    p = {r.arrival_time, r.detail_id};
    case (r.op)
      OP_APPEND: begin
        if (log_appends != '1) log_appends++;
        // scan newest to oldest, stop at first match
        for (int i = int'(log_held) - 1; i >= 0 && !hit; i--) begin
          slot = log_oldest + SLOT_W'(i);
          if (log_key[slot] == k) begin
            hit = 1'b1;
            if (log_occ[slot] != '1) log_occ[slot]++;
            log_pay[slot] = p;
            res.coalesced = 1'b1;
          end
        end
        if (!hit) begin
          slot = log_oldest + log_held[SLOT_W-1:0];
          log_key[slot] = k;
          log_pay[slot] = p;
          log_occ[slot] = CNT_W'(1);
          if (log_held >= DEPTH) begin
            log_oldest++;
            if (log_discards != '1) log_discards++;
            res.evicted_oldest = 1'b1;
          end else begin
            log_held++;
          end
        end
        res = with_entry(res, slot);
      end
      OP_READ: begin
        if (r.read_position < log_held) res = with_entry(res, log_oldest + r.read_position);
      end
      OP_CLEAR: begin
        log_oldest   = '0;
        log_held     = '0;
        log_appends  = '0;
        log_discards = '0;
      end
      default: begin
      end
    endcase
    res.occupied_count  = log_held;
    res.appended_count  = log_appends;
    res.discarded_count = log_discards;
    return res;
  endfunction

  function automatic report_req_t build_req(logic [1:0] op, logic [15:0] origin,
                                            logic [7:0] verdict, logic [15:0] subject,
                                            logic [15:0] sidx, logic [31:0] arrival,
                                            logic [15:0] detail, logic [3:0] pos);
    report_req_t r;
    r.op            = op;
    r.origin_id     = origin;
    r.verdict       = verdict;
    r.subject_id    = subject;
    r.subject_index = sidx;
    r.arrival_time  = arrival;
    r.detail_id     = detail;
    r.read_position = pos;
    return r;
  endfunction

  function automatic report_req_t random_fields(logic [1:0] op);
    return build_req(op, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                     $urandom, 16'($urandom), 4'($urandom));
  endfunction

  function automatic report_req_t with_key(report_req_t r, key_t k);
    {r.origin_id, r.verdict, r.subject_id, r.subject_index} = k;
    return r;
  endfunction

  function automatic report_req_t pick_mixed();
    report_req_t r;
    key_t        k;
    int          roll;
    int          bit_idx;
    roll = $urandom_range(0, 199);
    if (roll < 136) begin
      r = random_fields(OP_APPEND);
      if (roll < 110) begin
        r = with_key(r, key_pool[$urandom_range(0, pool_used - 1)]);
      end else if (roll < 124) begin
        // near miss: one key bit off a pooled key
        k = key_pool[$urandom_range(0, pool_used - 1)];
        bit_idx = $urandom_range(0, KEY_W - 1);
        k[bit_idx] = ~k[bit_idx];
        r = with_key(r, k);
      end
    end else if (roll < 188) begin
      r = random_fields(OP_READ);
    end else if (roll < 193) begin
      r = random_fields(OP_CLEAR);
    end else begin
      r = random_fields(OP_UNUSED);
    end
    return r;
  endfunction

  task automatic refresh_pool(int n);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = key_t'({$urandom, $urandom});
    pool_used = n;
  endtask

  task automatic pace_sender();
    if (!tx_bursty) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 24)) @(posedge clk);
    burst_left = $urandom_range(0, 9);
  endtask

  // Called at a rising edge; returns at the edge of the transfer (or after a gap).
  task automatic send_item(report_req_t r);
    in_valid         <= 1'b1;
    in_operation     <= r.op;
    in_origin_id     <= r.origin_id;
    in_verdict       <= r.verdict;
    in_subject_id    <= r.subject_id;
    in_subject_index <= r.subject_index;
    in_arrival_time  <= r.arrival_time;
    in_detail_id     <= r.detail_id;
    in_read_position <= r.read_position;
    do @(posedge clk); while (!in_ready);
    ring_outcomes.insert(ring_outcomes.size(), apply_to_ring(r));
    pace_sender();
  endtask

  task automatic run_mixed(int n);
    repeat (n) send_item(pick_mixed());
  endtask

  task automatic test_directed();
    tx_bursty = 1'b0;
    rx_stall  = 1'b0;
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'd0));
    send_item(build_req(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF, 4'hF));
    send_item(build_req(OP_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF, 4'hF));
    send_item(build_req(OP_APPEND, 0, 0, 0, 0, 0, 0, 4'd0));
    send_item(build_req(OP_APPEND, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF, 4'hF));
    // merge into the newest entry
    send_item(build_req(OP_APPEND, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'h1234_5678,
                        16'hBEEF, 4'd0));
    send_item(build_req(OP_APPEND, 0, 8'h80, 0, 0, 1, 1, 4'd0));
    send_item(build_req(OP_APPEND, 0, 0, 0, 16'd1, 2, 2, 4'd0));
    // merge into the oldest entry, past three non-matching ones
    send_item(build_req(OP_APPEND, 0, 0, 0, 0, 32'h8000_0000, 16'h8000, 4'd0));
    for (int i = 0; i < 5; i++) send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'(i)));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'hF));
    send_item(build_req(OP_UNUSED, 0, 0, 0, 0, 0, 0, 4'd0));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'd0));
    send_item(build_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 4'd0));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'd0));
    // stale entry with the same key must not be seen after clear
    send_item(build_req(OP_APPEND, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF, 4'hF));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'd0));
  endtask

  task automatic test_fill_evict();
    key_t        keys [20];
    report_req_t r;
    tx_bursty = 1'b0;
    rx_stall  = 1'b1;
    send_item(random_fields(OP_CLEAR));
    for (int i = 0; i < 20; i++) begin
      keys[i] = key_t'({$urandom, $urandom});
      keys[i][15:0] = 16'(i);  // distinct subject index keeps keys apart
      send_item(with_key(random_fields(OP_APPEND), keys[i]));
    end
    for (int i = 0; i < DEPTH; i++) begin
      r = random_fields(OP_READ);
      r.read_position = 4'(i);
      send_item(r);
    end
    send_item(with_key(random_fields(OP_APPEND), keys[19]));
    send_item(with_key(random_fields(OP_APPEND), keys[4]));
    send_item(with_key(random_fields(OP_APPEND), keys[0]));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'd0));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'hF));
  endtask

  task automatic test_random_steady();
    tx_bursty = 1'b0;
    rx_stall  = 1'b0;
    refresh_pool(6);
    run_mixed(200);
  endtask

  task automatic test_random_bursty();
    tx_bursty = 1'b1;
    rx_stall  = 1'b1;
    refresh_pool(20);
    run_mixed(250);
    refresh_pool(POOL_SIZE);
    run_mixed(200);
  endtask

  task automatic test_backpressure();
    tx_bursty = 1'b0;
    rx_stall  = 1'b0;
    refresh_pool(10);
    hold_req = 1'b1;
    run_mixed(24);
  endtask

  // Same key again and again: the count climbs on one entry
  task automatic test_repeated_merge();
    key_t k;
    tx_bursty = 1'b0;
    rx_stall  = 1'b0;
    k = key_t'({$urandom, $urandom});
    send_item(random_fields(OP_CLEAR));
    repeat (MERGE_REPEATS) send_item(with_key(random_fields(OP_APPEND), k));
    send_item(build_req(OP_READ, 0, 0, 0, 0, 0, 0, 4'd0));
  endtask

  task automatic test_random_stalled();
    tx_bursty = 1'b0;
    rx_stall  = 1'b1;
    refresh_pool(12);
    run_mixed(200);
  endtask

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Receiver: random stall runs, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rx_ready_next = 1'b0;
    end else if (!rx_stall) begin
      rx_ready_next = 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_state = ($urandom_range(0, 99) < 65);
        rx_run   = $urandom_range(1, 12);
      end
      rx_run--;
      rx_ready_next = rx_state;
    end
    out_ready <= rx_ready_next;
  end

  // Check every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.origin_id        = out_entry_origin_id;
      got.verdict          = out_entry_verdict;
      got.subject_id       = out_entry_subject_id;
      got.subject_index    = out_entry_subject_index;
      got.arrival_time     = out_entry_arrival_time;
      got.detail_id        = out_entry_detail_id;
      got.occurrence_count = out_entry_occurrence_count;
      got.coalesced        = out_coalesced;
      got.evicted_oldest   = out_evicted_oldest;
      got.occupied_count   = out_occupied_count;
      got.appended_count   = out_appended_count;
      got.discarded_count  = out_discarded_count;
      if (ring_outcomes.size() == 0) begin
        $error("result with nothing pending: origin %0h appended %0h",
               got.origin_id, got.appended_count);
        mismatches++;
      end else begin
        want = ring_outcomes.pop_front();
        compare_field("entry_origin_id", 32'(want.origin_id), 32'(got.origin_id));
        compare_field("entry_verdict", 32'(want.verdict), 32'(got.verdict));
        compare_field("entry_subject_id", 32'(want.subject_id), 32'(got.subject_id));
        compare_field("entry_subject_index", 32'(want.subject_index),
                      32'(got.subject_index));
        compare_field("entry_arrival_time", want.arrival_time, got.arrival_time);
        compare_field("entry_detail_id", 32'(want.detail_id), 32'(got.detail_id));
        compare_field("entry_occurrence_count", 32'(want.occurrence_count),
                      32'(got.occurrence_count));
        compare_field("coalesced", 32'(want.coalesced), 32'(got.coalesced));
        compare_field("evicted_oldest", 32'(want.evicted_oldest), 32'(got.evicted_oldest));
        compare_field("occupied_count", 32'(want.occupied_count), 32'(got.occupied_count));
        compare_field("appended_count", want.appended_count, got.appended_count);
        compare_field("discarded_count", want.discarded_count, got.discarded_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("coalescing_report_ring: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      log_key[i] = '0;
      log_pay[i] = '0;
      log_occ[i] = '0;
    end
    log_oldest   = '0;
    log_held     = '0;
    log_appends  = '0;
    log_discards = '0;
    refresh_pool(8);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_evict();
    test_random_steady();
    test_random_bursty();
    test_backpressure();
    test_repeated_merge();
    test_random_stalled();
    in_valid <= 1'b0;
    rx_stall = 1'b0;
    while (ring_outcomes.size() != 0) @(posedge clk);
    // drain: catch any stray result
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("coalescing_report_ring: match");
    end else begin
      $display("coalescing_report_ring: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/crr_pkg.sv
rtl/crr_queue.sv
rtl/crr_engine.sv
rtl/coalescing_report_ring.sv
tb/sv/tb_coalescing_report_ring.sv
